>>> hw/rtl/usv_pkg.sv
// Shared types and constants of the UTF-8 stream validator.
package usv_pkg;

   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic       done_res;
      logic       valid_res;
      logic [2:0] fault_code;
   } rsp_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_LEAD      = 3'd1,
      ERR_CONT      = 3'd2,
      ERR_TRUNC     = 3'd3,
      ERR_OVERLONG  = 3'd4,
      ERR_ABOVE     = 3'd5,
      ERR_SURROGATE = 3'd6
   } err_type;

   typedef enum logic [2:0] {
      KIND_ASCII = 3'd0,
      KIND_LEAD2 = 3'd1,
      KIND_LEAD3 = 3'd2,
      KIND_LEAD4 = 3'd3,
      KIND_CONT  = 3'd4,
      KIND_BAD   = 3'd5
   } kind_type;

   typedef struct packed {
      logic       is_end;
      kind_type   kind;
      logic [5:0] payload;
   } class_type;

   localparam int CP_W = 21;

   localparam logic [CP_W-1:0] MIN_LEN2      = 21'h00080;
   localparam logic [CP_W-1:0] MIN_LEN3      = 21'h00800;
   localparam logic [CP_W-1:0] MIN_LEN4      = 21'h10000;
   localparam logic [CP_W-1:0] MAX_CODE      = 21'h10FFFF;
   localparam logic [CP_W-1:0] SURROGATE_LO  = 21'h0D800;
   localparam logic [CP_W-1:0] SURROGATE_HI  = 21'h0DFFF;

endpackage

>>> hw/rtl/usv_queue.sv
// Small first-in first-out queue of words with push/full and pop/empty sides.
module usv_queue
   import usv_pkg::*;
#(
   parameter int  DEPTH     = 2,
   parameter type item_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type wr_data,
   output logic     full,
   input  logic     pop,
   output item_type rd_data,
   output logic     empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> hw/rtl/usv_front.sv
// Front end: classifies each incoming word by its UTF-8 byte pattern.
module usv_front
   import usv_pkg::*;
(
   input  logic      req_push,
   input  req_type   req_data,
   output logic      class_push,
   output class_type class_word
);

   logic [7:0] b;

   assign b          = req_data.data_byte;
   assign class_push = req_push;

   always_comb begin
      class_word.is_end  = req_data.op;
      class_word.payload = b[5:0];
      if (b[7] == 1'b0) begin
         class_word.kind = KIND_ASCII;
      end else if (b[7:6] == 2'b10) begin
         class_word.kind = KIND_CONT;
      end else if (b[7:5] == 3'b110) begin
         class_word.kind = KIND_LEAD2;
      end else if (b[7:4] == 4'b1110) begin
         class_word.kind = KIND_LEAD3;
      end else if (b[7:3] == 5'b11110) begin
         class_word.kind = KIND_LEAD4;
      end else begin
         class_word.kind = KIND_BAD;
      end
   end

endmodule

>>> hw/rtl/usv_back.sv
// Back end: decoder state, range checks and the per-word verdict.
module usv_back
   import usv_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      class_empty,
   input  class_type class_word,
   output logic      class_pop,
   input  logic      rsp_full,
   output logic      rsp_push,
   output rsp_type   rsp_word
);

   logic [1:0]      rem_ff, rem_in;
   logic [2:0]      len_ff, len_in;
   logic [CP_W-1:0] acc_ff, acc_in;
   err_type         err_ff, err_in;
   logic            step;
   logic [1:0]      rem_dec;
   logic [CP_W-1:0] acc_shift;
   logic [CP_W-1:0] minimum;
   err_type         err_out;

   assign step      = ~class_empty & ~rsp_full;
   assign class_pop = step;
   assign rsp_push  = step;
   assign rem_dec   = rem_ff - 2'd1;
   assign acc_shift = {acc_ff[CP_W-7:0], class_word.payload};

   always_comb begin
      case (len_ff)
         3'd2:    minimum = MIN_LEN2;
         3'd3:    minimum = MIN_LEN3;
         default: minimum = MIN_LEN4;
      endcase
   end

   always_comb begin
      rem_in  = rem_ff;
      len_in  = len_ff;
      acc_in  = acc_ff;
      err_in  = err_ff;
      err_out = err_ff;
      if (step) begin
         if (class_word.is_end) begin
            if (err_ff == ERR_NONE && rem_ff != 2'd0) begin
               err_out = ERR_TRUNC;
            end
            rem_in = '0;
            len_in = '0;
            acc_in = '0;
            err_in = ERR_NONE;
         end else begin
            if (err_ff == ERR_NONE) begin
               if (rem_ff == 2'd0) begin
                  case (class_word.kind)
                     KIND_ASCII: begin
                     end
                     KIND_LEAD2: begin
                        len_in = 3'd2;
                        rem_in = 2'd1;
                        acc_in = {16'd0, class_word.payload[4:0]};
                     end
                     KIND_LEAD3: begin
                        len_in = 3'd3;
                        rem_in = 2'd2;
                        acc_in = {17'd0, class_word.payload[3:0]};
                     end
                     KIND_LEAD4: begin
                        len_in = 3'd4;
                        rem_in = 2'd3;
                        acc_in = {18'd0, class_word.payload[2:0]};
                     end
                     default: begin
                        err_in = ERR_LEAD;
                     end
                  endcase
               end else if (class_word.kind != KIND_CONT) begin
                  err_in = ERR_CONT;
               end else begin
                  rem_in = rem_dec;
                  acc_in = acc_shift;
                  if (rem_dec == 2'd0) begin
                     if (acc_shift < minimum) begin
                        err_in = ERR_OVERLONG;
                     end else if (acc_shift > MAX_CODE) begin
                        err_in = ERR_ABOVE;
                     end else if (acc_shift >= SURROGATE_LO && acc_shift <= SURROGATE_HI) begin
                        err_in = ERR_SURROGATE;
                     end
                     len_in = '0;
                     acc_in = '0;
                  end
               end
            end
            err_out = err_in;
         end
      end
   end

   always_comb begin
      rsp_word.done_res   = class_word.is_end;
      rsp_word.valid_res  = (err_out == ERR_NONE);
      rsp_word.fault_code = err_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         len_ff <= '0;
         acc_ff <= '0;
         err_ff <= ERR_NONE;
      end else begin
         rem_ff <= rem_in;
         len_ff <= len_in;
         acc_ff <= acc_in;
         err_ff <= err_in;
      end
   end

endmodule

>>> hw/rtl/utf8_stream_validator.sv
// Top level of the UTF-8 stream validator.
//
// The block checks byte strings for well-formed UTF-8. Each input word carries
// one data byte, or with op set, the end of the string. Every input word gives
// exactly one result word: the running verdict and the first error code seen,
// or on the end word, the final verdict including truncation.
// Both channels behave like queues. An input word is taken on a clock edge
// with req_push high and req_full low; the oldest result stands on rsp_data
// while rsp_empty is low and leaves on an edge with rsp_pop high.
// The block takes one word per cycle while req_full is low, bound by the
// decode step of the back end, which stalls while the result queue is full.
// A classified-word queue separates the classifier from the decoder, and a
// result queue separates the decoder from the receiver. When the receiver
// stalls, the result queue fills, then the inner queue, and only then does
// req_full rise. Synchronous reset empties both queues and clears the
// decoder state, so the next word starts a new string.
module utf8_stream_validator
   import usv_pkg::*;
#(
   parameter int QUEUE_DEPTH  = 2,
   parameter int RESULT_DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   input  logic    rsp_pop,
   output rsp_type rsp_data,
   output logic    rsp_empty
);

   logic      class_push;
   class_type class_in_word;
   class_type class_out_word;
   logic      class_pop;
   logic      class_empty;
   logic      rsp_push;
   rsp_type   rsp_word;
   logic      rsp_full;

   usv_front u_front (
      .req_push   (req_push),
      .req_data   (req_data),
      .class_push (class_push),
      .class_word (class_in_word)
   );

   usv_queue #(
      .DEPTH     (QUEUE_DEPTH),
      .item_type (class_type)
   ) u_class_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (class_push),
      .wr_data (class_in_word),
      .full    (req_full),
      .pop     (class_pop),
      .rd_data (class_out_word),
      .empty   (class_empty)
   );

   usv_back u_back (
      .clock       (clock),
      .reset       (reset),
      .class_empty (class_empty),
      .class_word  (class_out_word),
      .class_pop   (class_pop),
      .rsp_full    (rsp_full),
      .rsp_push    (rsp_push),
      .rsp_word    (rsp_word)
   );

   usv_queue #(
      .DEPTH     (RESULT_DEPTH),
      .item_type (rsp_type)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_word),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_data),
      .empty   (rsp_empty)
   );

endmodule

>>> hw/rtl/usv_checker.sv
// Port-level checks of the UTF-8 stream validator and their binding.
module usv_checker
   import usv_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_push,
   input logic    req_full,
   input logic    rsp_pop,
   input rsp_type rsp_data,
   input logic    rsp_empty
);

   a_reset_empty : assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("Queues not empty after reset.");

   a_verdict_matches_code : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.valid_res == (rsp_data.fault_code == ERR_NONE)))
      else $error("Verdict disagrees with error code.");

   a_trunc_only_at_end : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.done_res) |-> (rsp_data.fault_code != ERR_TRUNC))
      else $error("Truncation reported on a data word.");

   a_stalled_result_holds : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("Waiting result changed or vanished.");

   a_push_makes_result : assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full && rsp_empty) |-> ##2 !rsp_empty)
      else $error("Accepted word gave no result.");

endmodule

bind utf8_stream_validator usv_checker u_usv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data),
   .rsp_empty (rsp_empty)
);

>>> bench/tb_utf8_stream_validator.sv
// Self-checking testbench of the UTF-8 stream validator with its own verdict predictor.
module tb_utf8_stream_validator;
   timeunit 1ns;
   timeprecision 1ps;
   import usv_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 200;
   localparam int RANDOM_WORDS = 1000;
   localparam int NOISE_WORDS  = 150;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   req_type req_data = '0;
   logic    req_full;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;
   logic    rsp_empty;

   utf8_stream_validator dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty)
   );

   // Predictor state.
   logic [1:0]      pend_conts = '0;
   logic [2:0]      open_len = '0;
   logic [CP_W-1:0] cp_acc = '0;
   err_type         first_fault = ERR_NONE;
   rsp_type         verdict_q[$];

   int error_count = 0;
   int words_sent = 0;
   int results_checked = 0;
   int strings_closed = 0;
   int faulty_strings = 0;
   int full_cycles = 0;
   int cycle_count = 0;

   int   burst_left = 0;
   logic steady_send = 1'b0;
   logic hold_request = 1'b0;
   logic draining = 1'b0;
   int   hold_left = 0;
   int   pop_mode = 0;
   int   pattern_left = 0;
   int   pop_phase = 0;
   rsp_type got_word;
   rsp_type want_word;

   logic [7:0] unit_bytes[4];
   logic [7:0] string_bytes[$];

   initial begin
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < 40) begin
         $display("mismatch at result %0d: %s got %0d expected %0d", results_checked, what,
                  got, want);
      end
      error_count++;
   endtask

   task automatic add_byte(input logic [7:0] b);
      string_bytes.insert(string_bytes.size(), b);
   endtask

   task automatic decode_word(input logic op, input logic [7:0] b);
      rsp_type         r;
      logic [CP_W-1:0] lowest;
      if (op) begin
         if (first_fault == ERR_NONE && pend_conts != 0) begin
            first_fault = ERR_TRUNC;
         end
         r.done_res   = 1'b1;
         r.valid_res  = (first_fault == ERR_NONE);
         r.fault_code = first_fault;
         strings_closed++;
         if (first_fault != ERR_NONE) begin
            faulty_strings++;
         end
         pend_conts  = '0;
         open_len    = '0;
         cp_acc      = '0;
         first_fault = ERR_NONE;
      end else begin
         if (first_fault == ERR_NONE) begin
            if (pend_conts == 0) begin
               if (!b[7]) begin
               end else if (b[7:5] == 3'b110) begin
                  open_len   = 3'd2;
                  cp_acc     = CP_W'(b[4:0]);
                  pend_conts = 2'd1;
               end else if (b[7:4] == 4'b1110) begin
                  open_len   = 3'd3;
                  cp_acc     = CP_W'(b[3:0]);
                  pend_conts = 2'd2;
               end else if (b[7:3] == 5'b11110) begin
                  open_len   = 3'd4;
                  cp_acc     = CP_W'(b[2:0]);
                  pend_conts = 2'd3;
               end else begin
                  first_fault = ERR_LEAD;
               end
            end else if (b[7:6] != 2'b10) begin
               first_fault = ERR_CONT;
            end else begin
               cp_acc     = {cp_acc[CP_W-7:0], b[5:0]};
               pend_conts = pend_conts - 2'd1;
               if (pend_conts == 0) begin
                  lowest = (open_len == 3'd2) ? MIN_LEN2 :
                           (open_len == 3'd3) ? MIN_LEN3 : MIN_LEN4;
                  if (cp_acc < lowest) begin
                     first_fault = ERR_OVERLONG;
                  end else if (cp_acc > MAX_CODE) begin
                     first_fault = ERR_ABOVE;
                  end else if (cp_acc >= SURROGATE_LO && cp_acc <= SURROGATE_HI) begin
                     first_fault = ERR_SURROGATE;
                  end
                  open_len = '0;
                  cp_acc   = '0;
               end
            end
         end
         r.done_res   = 1'b0;
         r.valid_res  = (first_fault == ERR_NONE);
         r.fault_code = first_fault;
      end
      verdict_q.insert(verdict_q.size(), r);
   endtask

   task automatic send_word(input logic op, input logic [7:0] b);
      req_type w;
      int      gap;
      if (burst_left == 0) begin
         gap = steady_send ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7));
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      w.op        = op;
      w.data_byte = b;
      req_push <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_full) @(posedge clock);
      decode_word(op, b);
      words_sent++;
      burst_left--;
   endtask

   task automatic send_string();
      int i;
      for (i = 0; i < string_bytes.size(); i++) begin
         send_word(1'b0, string_bytes[i]);
      end
      send_word(1'b1, 8'($urandom_range(0, 255)));
      string_bytes.delete();
   endtask

   task automatic encode_unit(input int len, input logic [CP_W-1:0] cp);
      case (len)
         1: begin
            unit_bytes[0] = {1'b0, cp[6:0]};
         end
         2: begin
            unit_bytes[0] = {3'b110, cp[10:6]};
            unit_bytes[1] = {2'b10, cp[5:0]};
         end
         3: begin
            unit_bytes[0] = {4'b1110, cp[15:12]};
            unit_bytes[1] = {2'b10, cp[11:6]};
            unit_bytes[2] = {2'b10, cp[5:0]};
         end
         default: begin
            unit_bytes[0] = {5'b11110, cp[20:18]};
            unit_bytes[1] = {2'b10, cp[17:12]};
            unit_bytes[2] = {2'b10, cp[11:6]};
            unit_bytes[3] = {2'b10, cp[5:0]};
         end
      endcase
   endtask

   task automatic append_unit(input int count);
      int i;
      for (i = 0; i < count; i++) begin
         add_byte(unit_bytes[i]);
      end
   endtask

   task automatic append_bytes(input logic [31:0] packed_bytes, input int count);
      int i;
      for (i = 0; i < count; i++) begin
         add_byte(packed_bytes[31-8*i -: 8]);
      end
   endtask

   task automatic test_directed();
      send_word(1'b1, 8'h00);
      append_bytes(32'h007FF48F, 4);
      append_bytes(32'hBFBF0000, 2);
      send_word(1'b0, string_bytes[0]);
      send_word(1'b0, string_bytes[1]);
      send_word(1'b0, string_bytes[2]);
      send_word(1'b0, string_bytes[3]);
      send_word(1'b0, string_bytes[4]);
      send_word(1'b0, string_bytes[5]);
      send_word(1'b1, 8'hFF);
      string_bytes.delete();
      append_bytes(32'hEDA08000, 3);
      send_string();
      append_bytes(32'hC2418000, 3);
      send_string();
      append_bytes(32'hE1800000, 2);
      send_string();
      append_bytes(32'hFF000000, 1);
      send_string();
      append_bytes(32'hF4908080, 4);
      send_string();
      append_bytes(32'hC0800000, 2);
      send_string();
   endtask

   task automatic add_random_unit();
      int              pick;
      int              len;
      logic [CP_W-1:0] lo;
      logic [CP_W-1:0] hi;
      logic [CP_W-1:0] cp;
      pick = $urandom_range(0, 99);
      len  = $urandom_range(1, 4);
      if (pick < 70) begin
         lo = (len == 1) ? 21'h0 : (len == 2) ? MIN_LEN2 : (len == 3) ? MIN_LEN3 : MIN_LEN4;
         hi = (len == 1) ? 21'h7F : (len == 2) ? 21'h7FF : (len == 3) ? 21'hFFFF : MAX_CODE;
         case ($urandom_range(0, 7))
            0: cp = lo;
            1: cp = hi;
            2: cp = (len == 3) ? SURROGATE_LO - 21'd1 : lo + 21'd1;
            3: cp = (len == 3) ? SURROGATE_HI + 21'd1 : hi - 21'd1;
            default: cp = CP_W'($urandom_range(int'(lo), int'(hi)));
         endcase
         encode_unit(len, cp);
         append_unit(len);
      end else if (pick < 78) begin
         len = $urandom_range(2, 4);
         hi  = (len == 2) ? MIN_LEN2 : (len == 3) ? MIN_LEN3 : MIN_LEN4;
         encode_unit(len, CP_W'($urandom_range(0, int'(hi) - 1)));
         append_unit(len);
      end else if (pick < 82) begin
         encode_unit(3, CP_W'($urandom_range(int'(SURROGATE_LO), int'(SURROGATE_HI))));
         append_unit(3);
      end else if (pick < 86) begin
         encode_unit(4, CP_W'($urandom_range(int'(MAX_CODE) + 1, 21'h1FFFFF)));
         append_unit(4);
      end else if (pick < 92) begin
         len = $urandom_range(2, 4);
         encode_unit(len, CP_W'($urandom_range(int'(MIN_LEN4), int'(MAX_CODE))));
         append_unit($urandom_range(1, len - 1));
      end else if (pick < 96) begin
         add_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h80, 8'hBF))
                                              : 8'($urandom_range(8'hF8, 8'hFF)));
      end else begin
         len = $urandom_range(2, 4);
         encode_unit(len, CP_W'($urandom_range(int'(MIN_LEN4), int'(MAX_CODE))));
         append_unit($urandom_range(1, len - 1));
         add_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 8'h7F))
                                              : 8'($urandom_range(8'hC0, 8'hFF)));
      end
   endtask

   task automatic test_random_strings();
      int stop_at;
      int units;
      int i;
      stop_at = words_sent + RANDOM_WORDS;
      while (words_sent < stop_at) begin
         units = $urandom_range(0, 8);
         for (i = 0; i < units; i++) begin
            add_random_unit();
         end
         send_string();
      end
   endtask

   task automatic test_backpressure();
      int i;
      hold_request = 1'b1;
      steady_send  = 1'b1;
      burst_left   = 0;
      for (i = 0; i < 80; i++) begin
         send_word(($urandom_range(0, 9) == 0), 8'($urandom_range(0, 255)));
      end
      send_word(1'b1, 8'h00);
      steady_send = 1'b0;
   endtask

   task automatic test_raw_noise();
      int i;
      for (i = 0; i < NOISE_WORDS; i++) begin
         send_word(($urandom_range(0, 7) == 0), 8'($urandom_range(0, 255)));
      end
      send_word(1'b1, 8'($urandom_range(0, 255)));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            got_word = rsp_data;
            if (verdict_q.size() == 0) begin
               report_mismatch("unexpected word, done_res", int'(got_word.done_res), 0);
            end else begin
               want_word = verdict_q.pop_front();
               if (got_word.done_res !== want_word.done_res) begin
                  report_mismatch("done_res", int'(got_word.done_res),
                                  int'(want_word.done_res));
               end
               if (got_word.valid_res !== want_word.valid_res) begin
                  report_mismatch("valid_res", int'(got_word.valid_res),
                                  int'(want_word.valid_res));
               end
               if (got_word.fault_code !== want_word.fault_code) begin
                  report_mismatch("fault_code", int'(got_word.fault_code),
                                  int'(want_word.fault_code));
               end
            end
            results_checked++;
         end
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (pattern_left == 0) begin
            pop_mode     = $urandom_range(0, 3);
            pattern_left = $urandom_range(16, 96);
         end else begin
            pattern_left--;
         end
         pop_phase++;
         if (draining) begin
            rsp_pop <= 1'b1;
         end else if (hold_left != 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            case (pop_mode)
               0: rsp_pop <= 1'b1;
               1: rsp_pop <= 1'($urandom_range(0, 1));
               2: rsp_pop <= ($urandom_range(0, 3) == 0);
               default: rsp_pop <= (pop_phase % 3 == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (!reset && req_full) begin
         full_cycles++;
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding", cycle_count,
                  verdict_q.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_strings();
      test_backpressure();
      test_raw_noise();
      req_push <= 1'b0;
      draining = 1'b1;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("sent %0d words in %0d strings, %0d strings faulty, %0d results checked",
               words_sent, strings_closed, faulty_strings, results_checked);
      $display("input held off by a full queue for %0d cycles, %0d mismatches",
               full_cycles, error_count);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/usv_pkg.sv
hw/rtl/usv_queue.sv
hw/rtl/usv_front.sv
hw/rtl/usv_back.sv
hw/rtl/utf8_stream_validator.sv
hw/rtl/usv_checker.sv
bench/tb_utf8_stream_validator.sv
